### src/sssp_pkg.sv
// Shared types and constants for the shortest path block.
package sssp_pkg;
  localparam int DIST_BITS = 24;
  localparam logic [DIST_BITS-1:0] DIST_MAX = {DIST_BITS{1'b1}};

  typedef enum logic [3:0] {
    ST_LOAD, ST_CLEAR, ST_EDGE_RD, ST_EDGE_WAIT, ST_A_RD, ST_A_WAIT, ST_RELAX_AB,
    ST_RELAX_BA, ST_ROUND, ST_OUT_RD, ST_OUT_WAIT, ST_OUT
  } state_t;

  typedef enum logic {
    CFG_NODE_COUNT = 1'b0,
    CFG_SOURCE_NODE = 1'b1
  } cfg_index_t;
endpackage

### src/sssp_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module sssp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end
endmodule

### src/single_source_shortest_path.sv
// Top level: edge loading, round relaxation and per-node result emission.
//
//  channel | direction | handshake         | payload
//  in      | input     | in_valid/in_ready | has_edge end_a end_b edge_weight final_item
//  out     | output    | out_valid/out_ready | node_index path_length reachable
//          |           |                   | edges_dropped last_result
//  cfg     | input     | cfg_valid/cfg_ready | cfg_index cfg_data
//
// A final item clears the distances, then each relaxation round visits every stored edge
// (one out of range is skipped), with reads serialized through the single read port of
// the distance RAM; at most MAX_NODES+1 rounds run. Each result is read through the same
// port. Reset is synchronous and needs no clearing pass. A stalled result holds its
// register until transferred.
module single_source_shortest_path #(
  parameter int MAX_NODES = 64,
  parameter int MAX_EDGES = 256,
  parameter int WEIGHT_BITS = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        has_edge,
  input  logic [5:0]  end_a,
  input  logic [5:0]  end_b,
  input  logic [15:0] edge_weight,
  input  logic        final_item,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [5:0]  node_index,
  output logic [23:0] path_length,
  output logic        reachable,
  output logic        edges_dropped,
  output logic        last_result,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [6:0]  cfg_data
);
  import sssp_pkg::*;

  localparam int NB = $clog2(MAX_NODES);
  localparam int EB = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
  localparam int CB = $clog2(MAX_EDGES + 1);
  localparam int RB = $clog2(MAX_NODES + 2);
  localparam int WB = (WEIGHT_BITS < 16) ? WEIGHT_BITS : 16;
  localparam int EW = 2 * NB + WB;
  localparam int DW = DIST_BITS + 1;

  state_t state, state_next;
  logic [6:0] node_count;
  logic [5:0] source_node;
  logic [CB-1:0] edge_total;
  logic drop_seen;
  logic [CB-1:0] eidx;
  logic [RB-1:0] round;
  logic changed;
  logic [NB:0] nidx;
  logic [NB-1:0] ea, eb;
  logic [WB-1:0] ew;
  logic [DW-1:0] da;

  // Effective node count.
  logic [6:0] n_eff;
  always_comb begin
    if (node_count == 7'd0) n_eff = 7'd1;
    else if (node_count > 7'(MAX_NODES)) n_eff = 7'(MAX_NODES);
    else n_eff = node_count;
  end

  logic in_fire;
  assign in_fire = in_valid && in_ready;
  logic edge_ok;
  assign edge_ok = ({1'b0, end_a} < n_eff) && ({1'b0, end_b} < n_eff)
                   && (edge_total < CB'(MAX_EDGES));

  // Edge RAM.
  logic e_we;
  logic [EB-1:0] e_waddr, e_raddr;
  logic [EW-1:0] e_wdata, e_rdata;
  assign e_we = in_fire && has_edge && edge_ok;
  assign e_waddr = edge_total[EB-1:0];
  assign e_wdata = {end_a[NB-1:0], end_b[NB-1:0], edge_weight[WB-1:0]};
  assign e_raddr = eidx[EB-1:0];
  sssp_ram #(.WIDTH(EW), .DEPTH(MAX_EDGES)) u_edges (
    .clk(clk), .wr_en(e_we), .wr_addr(e_waddr), .wr_data(e_wdata),
    .rd_addr(e_raddr), .rd_data(e_rdata)
  );

  // Distance RAM: {valid, distance}.
  logic d_we;
  logic [NB-1:0] d_waddr, d_raddr;
  logic [DW-1:0] d_wdata, d_rdata;
  sssp_ram #(.WIDTH(DW), .DEPTH(MAX_NODES)) u_dist (
    .clk(clk), .wr_en(d_we), .wr_addr(d_waddr), .wr_data(d_wdata),
    .rd_addr(d_raddr), .rd_data(d_rdata)
  );

  // The one shared adder and compare: candidate from da into d_rdata.
  logic [DIST_BITS:0] sum;
  logic [DIST_BITS-1:0] cand;
  logic improve;
  assign sum = {1'b0, da[DIST_BITS-1:0]} + (DIST_BITS+1)'(ew);
  assign cand = sum[DIST_BITS] ? DIST_MAX : sum[DIST_BITS-1:0];
  assign improve = da[DIST_BITS] && (!d_rdata[DIST_BITS] || cand < d_rdata[DIST_BITS-1:0]);

  logic edges_done, src_ok, edge_in_range;
  assign edges_done = (eidx == edge_total);
  assign src_ok = {1'b0, source_node} < n_eff;
  assign edge_in_range = ({1'b0, ea} < (NB+1)'(n_eff)) && ({1'b0, eb} < (NB+1)'(n_eff));

  always_comb begin
    state_next = state;
    unique case (state)
      ST_LOAD:      if (in_fire && final_item) state_next = ST_CLEAR;
      ST_CLEAR:     if (nidx == (NB+1)'(MAX_NODES - 1))
                      state_next = src_ok ? ST_EDGE_RD : ST_OUT_RD;
      ST_EDGE_RD:   state_next = edges_done ? ST_ROUND : ST_EDGE_WAIT;
      ST_EDGE_WAIT: state_next = ST_A_RD;
      ST_A_RD:      state_next = edge_in_range ? ST_A_WAIT : ST_EDGE_RD;
      ST_A_WAIT:    state_next = ST_RELAX_AB;
      ST_RELAX_AB:  state_next = ST_RELAX_BA;
      ST_RELAX_BA:  state_next = ST_EDGE_RD;
      ST_ROUND:     state_next = (changed && round < RB'(MAX_NODES)) ? ST_EDGE_RD : ST_OUT_RD;
      ST_OUT_RD:    state_next = ST_OUT_WAIT;
      ST_OUT_WAIT:  state_next = ST_OUT;
      ST_OUT:       if (out_ready) state_next = (last_result) ? ST_LOAD : ST_OUT_RD;
      default:      state_next = ST_LOAD;
    endcase
  end

  // RAM port control. Relaxation reads b (for a->b) while a is held in da,
  // then reads a back (for b->a) while the new b value sits in da.
  always_comb begin
    d_we = 1'b0;
    d_waddr = nidx[NB-1:0];
    d_wdata = '0;
    d_raddr = nidx[NB-1:0];
    unique case (state)
      ST_CLEAR: begin
        d_we = 1'b1;
        d_wdata = (nidx[NB-1:0] == source_node[NB-1:0] && src_ok) ? {1'b1, {DIST_BITS{1'b0}}}
                                                                 : '0;
      end
      ST_A_RD:     d_raddr = ea;
      ST_A_WAIT:   d_raddr = eb;
      ST_RELAX_AB: begin
        d_raddr = ea;
        d_waddr = eb;
        d_we = improve;
        d_wdata = {1'b1, cand};
      end
      ST_RELAX_BA: begin
        d_waddr = ea;
        d_we = improve;
        d_wdata = {1'b1, cand};
      end
      default: ;
    endcase
  end

  always_comb begin
    in_ready = (state == ST_LOAD);
    cfg_ready = (state == ST_LOAD);
    out_valid = (state == ST_OUT);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_LOAD;
      node_count <= 7'd64;
      source_node <= 6'd0;
      edge_total <= '0;
      drop_seen <= 1'b0;
      eidx <= '0;
      round <= '0;
      changed <= 1'b0;
      nidx <= '0;
    end else begin
      state <= state_next;
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index_t'(cfg_index))
          CFG_NODE_COUNT:  node_count <= cfg_data;
          CFG_SOURCE_NODE: source_node <= cfg_data[5:0];
          default: ;
        endcase
      end
      unique case (state)
        ST_LOAD: begin
          if (in_fire && has_edge) begin
            if (edge_ok) edge_total <= edge_total + 1'b1;
            else drop_seen <= 1'b1;
          end
          nidx <= '0;
          eidx <= '0;
          round <= '0;
          changed <= 1'b0;
        end
        ST_CLEAR: nidx <= (nidx == (NB+1)'(MAX_NODES - 1)) ? '0 : nidx + 1'b1;
        // The edge read issued in ST_EDGE_RD is on the RAM output here.
        ST_EDGE_WAIT: begin
          eidx <= eidx + 1'b1;
          {ea, eb, ew} <= e_rdata;
        end
        ST_RELAX_AB: begin
          da <= improve ? {1'b1, cand} : d_rdata;
          if (improve) changed <= 1'b1;
        end
        ST_RELAX_BA: if (improve) changed <= 1'b1;
        ST_ROUND: begin
          round <= round + 1'b1;
          changed <= 1'b0;
          eidx <= '0;
        end
        ST_OUT_WAIT: begin
          node_index <= 6'(nidx);
          reachable <= d_rdata[DIST_BITS];
          path_length <= d_rdata[DIST_BITS] ? d_rdata[DIST_BITS-1:0] : '0;
          edges_dropped <= drop_seen;
          last_result <= (nidx + 1'b1) == (NB+1)'(n_eff);
        end
        ST_OUT: if (out_ready) begin
          nidx <= nidx + 1'b1;
          if (last_result) begin
            edge_total <= '0;
            drop_seen <= 1'b0;
          end
        end
        default: ;
      endcase
      // da holds the a-side value during the a->b relaxation.
      if (state == ST_A_WAIT) da <= d_rdata;
    end
  end
endmodule

### dv/tb_single_source_shortest_path.sv
// Testbench for the shortest path block: directed and random graphs, checked per node.
`timescale 1ns / 1ps
module tb_single_source_shortest_path;
  import sssp_pkg::*;

  localparam int NODES_MAX = 64;
  localparam int EDGES_MAX = 256;
  localparam int CYCLE_LIMIT = 3000000;

  typedef struct {
    logic [5:0]  node;
    logic [23:0] plen;
    logic        reach;
    logic        dropped;
    logic        last;
  } node_result_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic        has_edge = 1'b0;
  logic [5:0]  end_a = '0;
  logic [5:0]  end_b = '0;
  logic [15:0] edge_weight = '0;
  logic        final_item = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [5:0]  node_index;
  logic [23:0] path_length;
  logic        reachable;
  logic        edges_dropped;
  logic        last_result;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic        cfg_index = CFG_NODE_COUNT;
  logic [6:0]  cfg_data = '0;

  single_source_shortest_path dut (.*);

  always #6 clk = ~clk;

  // Model state of the block.
  logic [5:0]  stored_a [EDGES_MAX];
  logic [5:0]  stored_b [EDGES_MAX];
  logic [15:0] stored_w [EDGES_MAX];
  int          stored_cnt = 0;
  logic        drop_flag = 1'b0;
  logic [6:0]  node_count_reg = 7'd64;
  logic [5:0]  source_reg = '0;

  node_result_t expected_q[$];
  int errors = 0;
  int results_seen = 0;
  int graphs_sent = 0;
  int cycle_cnt = 0;
  bit rx_hold = 1'b0;
  bit no_idle = 1'b0;

  function automatic int active_nodes();
    if (node_count_reg == 0) return 1;
    if (node_count_reg > NODES_MAX) return NODES_MAX;
    return node_count_reg;
  endfunction

  function automatic void enqueue_result(node_result_t r);
    expected_q = {expected_q, r};
  endfunction

  // Relax every stored edge that is in range in rounds and queue one result per node.
  function automatic void solve_distances();
    int          n;
    logic [23:0] best_len [NODES_MAX];
    logic        known [NODES_MAX];
    logic        changed;
    logic [24:0] cand;
    int          x, y;
    node_result_t r;
    n = active_nodes();
    for (int i = 0; i < NODES_MAX; i++) begin
      best_len[i] = '0;
      known[i] = 1'b0;
    end
    if (source_reg < n) begin
      known[source_reg] = 1'b1;
      changed = 1'b1;
      for (int round = 0; changed && round <= NODES_MAX; round++) begin
        changed = 1'b0;
        for (int e = 0; e < stored_cnt; e++) begin
          if (stored_a[e] >= n || stored_b[e] >= n) continue;
          for (int dir = 0; dir < 2; dir++) begin
            x = dir ? stored_b[e] : stored_a[e];
            y = dir ? stored_a[e] : stored_b[e];
            if (!known[x]) continue;
            cand = {1'b0, best_len[x]} + stored_w[e];
            if (cand > 25'(DIST_MAX)) cand = 25'(DIST_MAX);
            if (!known[y] || cand[23:0] < best_len[y]) begin
              best_len[y] = cand[23:0];
              known[y] = 1'b1;
              changed = 1'b1;
            end
          end
        end
      end
    end
    for (int i = 0; i < n; i++) begin
      r.node = i[5:0];
      r.plen = known[i] ? best_len[i] : '0;
      r.reach = known[i];
      r.dropped = drop_flag;
      r.last = (i == n - 1);
      enqueue_result(r);
    end
    stored_cnt = 0;
    drop_flag = 1'b0;
  endfunction

  function automatic void accept_item(logic he, logic [5:0] a, logic [5:0] b,
                                      logic [15:0] w, logic fin);
    int n;
    n = active_nodes();
    if (he) begin
      if (a >= n || b >= n || stored_cnt >= EDGES_MAX) begin
        drop_flag = 1'b1;
      end else begin
        stored_a[stored_cnt] = a;
        stored_b[stored_cnt] = b;
        stored_w[stored_cnt] = w;
        stored_cnt++;
      end
    end
    if (fin) begin
      graphs_sent++;
      solve_distances();
    end
  endfunction

  // Handshakes are judged at the falling edge, where everything is settled.
  task automatic send_item(logic he, logic [5:0] a, logic [5:0] b, logic [15:0] w,
                           logic fin);
    int gap;
    gap = no_idle ? 0 : $urandom_range(3);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    has_edge <= he;
    end_a <= a;
    end_b <= b;
    edge_weight <= w;
    final_item <= fin;
    do @(negedge clk); while (!in_ready);
    @(posedge clk);
    accept_item(he, a, b, w, fin);
  endtask

  task automatic send_edge(int a, int b, int w);
    send_item(1'b1, a[5:0], b[5:0], w[15:0], 1'b0);
  endtask

  task automatic close_graph();
    send_item(1'b0, 6'($urandom), 6'($urandom), 16'($urandom), 1'b1);
  endtask

  // Lets all results drain and the block settle before a register write.
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (30) @(posedge clk);
  endtask

  task automatic write_reg(cfg_index_t idx, int value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value[6:0];
    do @(negedge clk); while (!cfg_ready);
    @(posedge clk);
    if (idx == CFG_NODE_COUNT) node_count_reg = value[6:0];
    else source_reg = value[5:0];
  endtask

  task automatic set_graph_regs(int n, int s);
    wait_drained();
    write_reg(CFG_NODE_COUNT, n);
    write_reg(CFG_SOURCE_NODE, s);
    cfg_valid <= 1'b0;
  endtask

  task automatic test_small_graph();
    set_graph_regs(8, 0);
    send_edge(0, 1, 0);
    send_edge(1, 2, 16'hFFFF);
    send_edge(0, 2, 70000 & 16'hFFFF);
    send_edge(3, 3, 5);
    send_edge(2, 7, 12);
    send_item(1'b0, 6'd0, 6'd0, 16'd0, 1'b0);
    send_edge(7, 6, 1);
    send_item(1'b1, 6'd5, 6'd6, 16'd3, 1'b1);
  endtask

  task automatic test_dropped_edges();
    set_graph_regs(8, 2);
    send_edge(63, 1, 9);
    send_edge(2, 8, 9);
    send_edge(2, 4, 9);
    close_graph();
    // The drop flag must clear after the emission.
    send_item(1'b1, 6'd4, 6'd2, 16'd1, 1'b1);
  endtask

  task automatic test_count_extremes();
    set_graph_regs(0, 0);
    send_item(1'b1, 6'd0, 6'd1, 16'd4, 1'b1);
    set_graph_regs(127, 63);
    send_edge(63, 0, 16'hFFFF);
    send_edge(0, 62, 16'h8000);
    close_graph();
    set_graph_regs(64, 62);
    send_item(1'b1, 6'd62, 6'd63, 16'd7, 1'b1);
  endtask

  task automatic test_source_out_of_range();
    set_graph_regs(8, 10);
    send_edge(0, 1, 2);
    close_graph();
  endtask

  task automatic test_count_lowered();
    set_graph_regs(16, 0);
    send_edge(0, 12, 1);
    send_edge(12, 3, 1);
    send_edge(0, 3, 50);
    set_graph_regs(4, 0);
    close_graph();
  endtask

  task automatic test_store_full();
    set_graph_regs(64, 0);
    for (int i = 0; i < EDGES_MAX + 2; i++)
      send_edge($urandom_range(63), $urandom_range(63), $urandom);
    close_graph();
  endtask

  // The receiver stops for a long stretch while two graphs are offered.
  task automatic test_output_stall();
    set_graph_regs(12, 1);
    fork
      begin
        rx_hold = 1'b1;
        repeat (400) @(posedge clk);
        rx_hold = 1'b0;
      end
    join_none
    for (int g = 0; g < 2; g++) begin
      for (int i = 0; i < 6; i++)
        send_edge($urandom_range(11), $urandom_range(11), $urandom_range(100));
      close_graph();
    end
  endtask

  task automatic test_random_graphs();
    int n, s, edges, a, b, w;
    for (int g = 0; g < 6; g++) begin
      no_idle = (g % 6 == 5);
      n = ($urandom_range(7) == 0) ? $urandom_range(127) : $urandom_range(16, 2);
      s = ($urandom_range(9) == 0) ? $urandom_range(63) : $urandom_range((n > 1 ? n : 1) - 1);
      set_graph_regs(n, s);
      if (n == 0) n = 1;
      if (n > NODES_MAX) n = NODES_MAX;
      edges = $urandom_range(12, 2);
      for (int i = 0; i < edges; i++) begin
        a = $urandom_range(n - 1);
        b = $urandom_range(n - 1);
        w = $urandom_range(3) == 0 ? $urandom : $urandom_range(40);
        case ($urandom_range(19))
          0: send_item(1'b0, 6'($urandom), 6'($urandom), 16'($urandom), 1'b0);
          1: send_edge($urandom_range(63), $urandom_range(63), w);
          default: send_edge(a, b, w);
        endcase
      end
      if ($urandom_range(1)) send_item(1'b1, 6'($urandom_range(n - 1)),
                                       6'($urandom_range(n - 1)), 16'($urandom), 1'b1);
      else close_graph();
    end
    no_idle = 1'b0;
  endtask

  // Receiver: random wait before each result, plus the long hold when asked.
  initial begin
    int gap;
    @(negedge rst);
    forever begin
      gap = no_idle ? 0 : $urandom_range(3);
      if (gap > 0 || rx_hold) begin
        out_ready <= 1'b0;
        repeat (gap) @(posedge clk);
        while (rx_hold) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(negedge clk); while (!out_valid);
      @(posedge clk);
    end
  end

  always @(negedge clk) begin
    node_result_t e;
    if (!rst && out_valid && out_ready) begin
      results_seen++;
      if (expected_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected result for node %0d", $time, node_index);
      end else begin
        e = expected_q.pop_front();
        if (node_index !== e.node || path_length !== e.plen || reachable !== e.reach ||
            edges_dropped !== e.dropped || last_result !== e.last) begin
          errors++;
          $display("%0t: mismatch expected node %0d len %0d reach %0b drop %0b last %0b",
                   $time, e.node, e.plen, e.reach, e.dropped, e.last);
          $display("%0t:          actual node %0d len %0d reach %0b drop %0b last %0b",
                   $time, node_index, path_length, reachable, edges_dropped, last_result);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles", cycle_cnt);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_small_graph();
    test_dropped_edges();
    test_count_extremes();
    test_source_out_of_range();
    test_count_lowered();
    test_store_full();
    test_output_stall();
    test_random_graphs();
    wait_drained();
    $display("Covered %0d graphs and %0d node results, with drops, full store,", graphs_sent,
             results_seen);
    $display("count and source extremes, and a long output stall.");
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end
endmodule
